### design/orb_pkg.sv
// shared constants and types for the overwriting ring buffer
package orb_pkg;

    // field widths
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned RIDX_W   = 8;
    localparam int unsigned CAPREG_W = 9;
    localparam int unsigned FILL_W   = 9;
    localparam int unsigned DROP_W   = 32;

    // storage defaults
    localparam int unsigned DEFAULT_DEPTH = 256;
    localparam int unsigned CAP_RESET     = 256;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POP   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PEEK  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd3;

    // result fields that the control logic hands to the output register
    typedef struct packed {
        logic              status;
        logic              evicted;
        logic              is_read;
        logic [FILL_W-1:0] fill_count;
        logic [DROP_W-1:0] dropped;
    } t_result;

endpackage

### design/overwrite_ring_buffer.sv
// overwriting ring buffer: one action per word, one result per accepted word
// a result is valid in the cycle after its word is accepted
// throughput: one word per cycle while results are taken, set by the single ram port
// a pending result holds the input off until it is taken or leaves in that cycle
// reset: pointers, fill and drop counts cleared, capacity 256 limited to depth
// stored words are not cleared; only entries written since the last clear are read
module overwrite_ring_buffer import orb_pkg::*; #(
    parameter int unsigned DEPTH = DEFAULT_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic        [CAPREG_W-1:0] i_cfg_wdata,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic        [ACTION_W-1:0] i_action,
    input  logic signed [WORD_W-1:0]   i_push_value,
    input  logic        [RIDX_W-1:0]   i_recency_index,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_status,
    output logic                       o_evicted,
    output logic signed [WORD_W-1:0]   o_read_value,
    output logic        [FILL_W-1:0]   o_fill_count,
    output logic        [DROP_W-1:0]   o_dropped_total
);

    localparam int unsigned PTR_W = $clog2(DEPTH);

    logic              fire;
    t_result           res;
    t_result           r_res;
    logic              r_valid;
    logic              mem_we, mem_re;
    logic [PTR_W-1:0]  mem_addr;
    logic [WORD_W-1:0] mem_wdata, mem_rdata;

    // accept whenever the result slot is free or drains now
    assign o_ready = !r_valid || i_ready;
    assign fire    = i_valid && o_ready;

    orb_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_fire         (fire),
        .i_action       (i_action),
        .i_push_value   (i_push_value),
        .i_recency_index(i_recency_index),
        .o_res          (res),
        .o_mem_we       (mem_we),
        .o_mem_re       (mem_re),
        .o_mem_addr     (mem_addr),
        .o_mem_wdata    (mem_wdata)
    );

    orb_ram #(
        .WIDTH(WORD_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_re   (mem_re),
        .i_addr (mem_addr),
        .i_wdata(mem_wdata),
        .o_rdata(mem_rdata)
    );

    // result register, ram read data moves with it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= res;
        end
    end

    // result ports
    assign o_valid         = r_valid;
    assign o_status        = r_res.status;
    assign o_evicted       = r_res.evicted;
    assign o_read_value    = r_res.is_read ? mem_rdata : '0;
    assign o_fill_count    = r_res.fill_count;
    assign o_dropped_total = r_res.dropped;

    // an accepted word always leaves a result behind
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> o_valid)
        else $error("accepted word produced no result");

    // an eviction only happens on a successful push into a full ring
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_evicted |-> !o_status && o_fill_count != '0 && o_read_value == '0)
        else $error("eviction reported with inconsistent fields");

    // a failed action returns zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_read_value == '0 && !o_evicted)
        else $error("failed action returned data");

endmodule

### design/orb_ram.sv
// generic single port ram with registered read
module orb_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/orb_ctrl.sv
// ring pointers, fill and drop counters, capacity register and address logic
module orb_ctrl import orb_pkg::*; #(
    parameter int unsigned DEPTH = DEFAULT_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CAPREG_W-1:0]      i_cfg_wdata,
    input  logic                     i_fire,
    input  logic [ACTION_W-1:0]      i_action,
    input  logic [WORD_W-1:0]        i_push_value,
    input  logic [RIDX_W-1:0]        i_recency_index,
    output t_result                  o_res,
    output logic                     o_mem_we,
    output logic                     o_mem_re,
    output logic [$clog2(DEPTH)-1:0] o_mem_addr,
    output logic [WORD_W-1:0]        o_mem_wdata
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CAP_W = $clog2(DEPTH + 1);
    localparam int unsigned SUM_W = ((CAP_W > RIDX_W) ? CAP_W : RIDX_W) + 1;

    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [CAP_W-1:0]  r_count, n_count;
    logic [CAP_W-1:0]  r_cap;
    logic [DROP_W-1:0] r_drop, n_drop;
    logic [CAP_W-1:0]  wp_inc;
    logic [SUM_W-1:0]  pop_sum, peek_sum, cap_ext;
    logic [SUM_W-1:0]  pop_pos, peek_pos;

    // capacity limited to one entry up to the ring depth
    function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAPREG_W-1:0] v);
        logic [CAP_W-1:0] c;
        if (v == '0) begin
            c = CAP_W'(1);
        end else if (32'(v) > 32'(DEPTH)) begin
            c = CAP_W'(DEPTH);
        end else begin
            c = CAP_W'(v);
        end
        return c;
    endfunction

    // wrapped positions of the oldest entry and of the peeked entry
    always_comb begin
        cap_ext  = SUM_W'(r_cap);
        wp_inc   = CAP_W'(r_wp) + CAP_W'(1);
        pop_sum  = SUM_W'(r_wp) + cap_ext - SUM_W'(r_count);
        peek_sum = SUM_W'(r_wp) + cap_ext - SUM_W'(1) - SUM_W'(i_recency_index);
        pop_pos  = (pop_sum >= cap_ext) ? pop_sum - cap_ext : pop_sum;
        peek_pos = (peek_sum >= cap_ext) ? peek_sum - cap_ext : peek_sum;
    end

    // next state, memory request and result fields for one word
    always_comb begin
        n_wp        = r_wp;
        n_count     = r_count;
        n_drop      = r_drop;
        o_mem_we    = 1'b0;
        o_mem_re    = 1'b0;
        o_mem_addr  = r_wp;
        o_mem_wdata = i_push_value;
        o_res       = '0;
        if (i_fire) begin
            unique case (i_action)
                ACT_PUSH: begin
                    o_mem_we = 1'b1;
                    n_wp     = (wp_inc == r_cap) ? '0 : PTR_W'(wp_inc);
                    if (r_count < r_cap) begin
                        n_count = r_count + CAP_W'(1);
                    end else begin
                        o_res.evicted = 1'b1;
                        n_drop        = r_drop + DROP_W'(1);
                    end
                end
                ACT_POP: begin
                    if (r_count == '0) begin
                        o_res.status = 1'b1;
                    end else begin
                        o_res.is_read = 1'b1;
                        o_mem_re      = 1'b1;
                        o_mem_addr    = pop_pos[PTR_W-1:0];
                        n_count       = r_count - CAP_W'(1);
                    end
                end
                ACT_PEEK: begin
                    if (SUM_W'(i_recency_index) >= SUM_W'(r_count)) begin
                        o_res.status = 1'b1;
                    end else begin
                        o_res.is_read = 1'b1;
                        o_mem_re      = 1'b1;
                        o_mem_addr    = peek_pos[PTR_W-1:0];
                    end
                end
                ACT_CLEAR: begin
                    n_wp    = '0;
                    n_count = '0;
                    n_drop  = '0;
                end
                default: begin
                    n_wp = r_wp;
                end
            endcase
        end
        o_res.fill_count = FILL_W'(n_count);
        o_res.dropped    = n_drop;
    end

    // state registers, a capacity write empties the ring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= clamp_cap(CAPREG_W'(CAP_RESET));
            r_wp    <= '0;
            r_count <= '0;
            r_drop  <= '0;
        end else if (i_cfg_we) begin
            r_cap   <= clamp_cap(i_cfg_wdata);
            r_wp    <= '0;
            r_count <= '0;
            r_drop  <= '0;
        end else begin
            r_wp    <= n_wp;
            r_count <= n_count;
            r_drop  <= n_drop;
        end
    end

endmodule

### verif/overwrite_ring_buffer_tb.sv
// testbench for the overwriting ring buffer: directed and random words checked against a predictor
module overwrite_ring_buffer_tb;
    import orb_pkg::*;

    localparam int unsigned RING_DEPTH = DEFAULT_DEPTH;

    // expected fields of one result word
    typedef struct {
        logic                     status;
        logic                     evicted;
        logic signed [WORD_W-1:0] read_value;
        logic [FILL_W-1:0]        fill_count;
        logic [DROP_W-1:0]        dropped_total;
    } t_ring_result;

    logic                       i_clk           = 1'b0;
    logic                       i_rst_n         = 1'b0;
    logic                       i_cfg_we        = 1'b0;
    logic        [CAPREG_W-1:0] i_cfg_wdata     = '0;
    logic                       i_valid         = 1'b0;
    logic                       o_ready;
    logic        [ACTION_W-1:0] i_action        = ACT_PUSH;
    logic signed [WORD_W-1:0]   i_push_value    = '0;
    logic        [RIDX_W-1:0]   i_recency_index = '0;
    logic                       o_valid;
    logic                       i_ready         = 1'b0;
    logic                       o_status;
    logic                       o_evicted;
    logic signed [WORD_W-1:0]   o_read_value;
    logic        [FILL_W-1:0]   o_fill_count;
    logic        [DROP_W-1:0]   o_dropped_total;

    // predictor state
    logic [WORD_W-1:0] ring_words [RING_DEPTH];
    int unsigned       ring_head;
    int unsigned       ring_fill;
    int unsigned       ring_cap;
    logic [DROP_W-1:0] ring_drops;

    t_ring_result pending_results [$];
    int           mismatch_count = 0;
    int           result_count   = 0;

    // sender burst and receiver stall control
    int           burst_left        = 0;
    bit           sender_no_gaps    = 1'b0;
    bit           receiver_no_stall = 1'b0;
    logic [15:0]  stall_pattern     = '1;
    int           stall_count       = 0;

    overwrite_ring_buffer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_push_value    (i_push_value),
        .i_recency_index (i_recency_index),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_evicted       (o_evicted),
        .o_read_value    (o_read_value),
        .o_fill_count    (o_fill_count),
        .o_dropped_total (o_dropped_total)
    );

    always #1 i_clk = ~i_clk;

    // capacity actually in use for a written register value
    function automatic int unsigned capacity_in_use(input logic [CAPREG_W-1:0] v);
        if (v == 0) return 1;
        if (32'(v) > RING_DEPTH) return RING_DEPTH;
        return 32'(v);
    endfunction

    // empty the ring as a capacity write does, and zero the model's words
    function automatic void empty_ring_model(input logic [CAPREG_W-1:0] cap_value);
        ring_cap   = capacity_in_use(cap_value);
        ring_head  = 0;
        ring_fill  = 0;
        ring_drops = '0;
        foreach (ring_words[k]) ring_words[k] = '0;
    endfunction

    // apply one action to the ring and return the result it yields
    function automatic t_ring_result ring_apply(input logic [ACTION_W-1:0] act,
                                                input logic [WORD_W-1:0] val,
                                                input logic [RIDX_W-1:0] ridx);
        t_ring_result r;
        int unsigned  pos;
        r.status     = 1'b0;
        r.evicted    = 1'b0;
        r.read_value = '0;
        if (ring_head >= ring_cap) ring_head = 0;
        case (act)
            ACT_PUSH: begin
                ring_words[ring_head] = val;
                ring_head++;
                if (ring_head >= ring_cap) ring_head = 0;
                if (ring_fill < ring_cap) begin
                    ring_fill++;
                end else begin
                    r.evicted  = 1'b1;
                    ring_drops = ring_drops + 1'b1;
                end
            end
            ACT_POP: begin
                if (ring_fill == 0) begin
                    r.status = 1'b1;
                end else begin
                    pos = ring_head + ring_cap - ring_fill;
                    if (pos >= ring_cap) pos -= ring_cap;
                    r.read_value = ring_words[pos];
                    ring_fill--;
                end
            end
            ACT_PEEK: begin
                if (32'(ridx) >= ring_fill) begin
                    r.status = 1'b1;
                end else begin
                    pos = ring_head + ring_cap - 1 - 32'(ridx);
                    if (pos >= ring_cap) pos -= ring_cap;
                    r.read_value = ring_words[pos];
                end
            end
            default: begin
                ring_head  = 0;
                ring_fill  = 0;
                ring_drops = '0;
            end
        endcase
        r.fill_count    = ring_fill[FILL_W-1:0];
        r.dropped_total = ring_drops;
        return r;
    endfunction

    // receiver: rotating stall pattern, refreshed now and then
    always @(negedge i_clk) begin
        if (stall_count == 0) begin
            stall_count <= $urandom_range(16, 64);
            case ($urandom_range(0, 3))
                0: stall_pattern <= '1;
                1: stall_pattern <= 16'($urandom | $urandom);
                2: stall_pattern <= 16'($urandom);
                default: stall_pattern <= 16'($urandom & $urandom);
            endcase
        end else begin
            stall_count   <= stall_count - 1;
            stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
        end
        i_ready <= receiver_no_stall | stall_pattern[15];
    end

    // result checker
    always @(posedge i_clk) begin
        t_ring_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result %0d: unexpected word status=%0d fill=%0d",
                             result_count, o_status, o_fill_count);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_evicted !== want.evicted ||
                    o_read_value !== want.read_value || o_fill_count !== want.fill_count ||
                    o_dropped_total !== want.dropped_total) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result %0d: expected st=%0d ev=%0d rd=%0d fill=%0d drop=%0d,",
                                  " got st=%0d ev=%0d rd=%0d fill=%0d drop=%0d"},
                                 result_count, want.status, want.evicted, want.read_value,
                                 want.fill_count, want.dropped_total, o_status, o_evicted,
                                 o_read_value, o_fill_count, o_dropped_total);
                end
            end
            result_count++;
        end
    end

    // send one word, with random gaps between bursts
    task automatic send_word(input logic [ACTION_W-1:0] act, input logic [WORD_W-1:0] val,
                             input logic [RIDX_W-1:0] ridx);
        int gap;
        if (!sender_no_gaps && burst_left == 0) begin
            gap        = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        if (burst_left > 0) burst_left--;
        @(negedge i_clk);
        i_action        <= act;
        i_push_value    <= val;
        i_recency_index <= ridx;
        i_valid         <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_results.push_back(ring_apply(act, val, ridx));
    endtask

    // hold the sender until every result is back, then let the block settle
    task automatic wait_for_results();
        @(negedge i_clk);
        i_valid   <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // capacity write while the block is idle
    task automatic write_capacity(input logic [CAPREG_W-1:0] v);
        wait_for_results();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        empty_ring_model(v);
    endtask

    // random words, weights in percent; clear takes what is left
    task automatic random_words(input int n, input int push_w, input int pop_w,
                                input int peek_w);
        int               r;
        logic [WORD_W-1:0] val;
        logic [RIDX_W-1:0] ridx;
        logic [ACTION_W-1:0] act;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < push_w) act = ACT_PUSH;
            else if (r < push_w + pop_w) act = ACT_POP;
            else if (r < push_w + pop_w + peek_w) act = ACT_PEEK;
            else act = ACT_CLEAR;
            case ($urandom_range(0, 11))
                0: val = 32'h7fff_ffff;
                1: val = 32'h8000_0000;
                2: val = 32'h0;
                3: val = 32'hffff_ffff;
                default: val = $urandom;
            endcase
            if (ring_fill > 0 && $urandom_range(0, 3) != 0)
                ridx = RIDX_W'($urandom_range(0, ring_fill - 1));
            else
                ridx = RIDX_W'($urandom_range(0, 255));
            send_word(act, val, ridx);
        end
    endtask

    // edges of every field and action, and the capacity extremes
    task automatic test_directed_cases();
        send_word(ACT_POP,   32'h0, 8'h0);
        send_word(ACT_PEEK,  32'h0, 8'h0);
        send_word(ACT_PUSH,  32'h7fff_ffff, 8'hff);
        send_word(ACT_PUSH,  32'h8000_0000, 8'h0);
        send_word(ACT_PUSH,  32'h0, 8'h55);
        send_word(ACT_PUSH,  32'hffff_ffff, 8'haa);
        send_word(ACT_PEEK,  32'h0, 8'd0);
        send_word(ACT_PEEK,  32'h0, 8'd3);
        send_word(ACT_PEEK,  32'h0, 8'd4);
        send_word(ACT_PEEK,  32'h0, 8'd255);
        send_word(ACT_POP,   32'h0, 8'h0);
        send_word(ACT_CLEAR, 32'hffff_ffff, 8'hff);
        send_word(ACT_POP,   32'h0, 8'h0);
        write_capacity(9'd1);
        send_word(ACT_PUSH,  32'd5, 8'h0);
        send_word(ACT_PUSH,  32'd6, 8'h0);
        send_word(ACT_PEEK,  32'h0, 8'd0);
        send_word(ACT_PEEK,  32'h0, 8'd1);
        send_word(ACT_POP,   32'h0, 8'h0);
        send_word(ACT_POP,   32'h0, 8'h0);
        // zero capacity behaves as one entry
        write_capacity(9'd0);
        send_word(ACT_PUSH,  32'ha5a5_a5a5, 8'h0);
        send_word(ACT_PUSH,  32'h5a5a_5a5a, 8'h0);
        send_word(ACT_CLEAR, 32'h0, 8'h0);
        // oversized capacity behaves as full depth
        write_capacity(9'd511);
        send_word(ACT_PUSH,  32'd1, 8'h0);
        send_word(ACT_PEEK,  32'h0, 8'd0);
    endtask

    // rings of one to three entries, frequent eviction and wrap
    task automatic test_tiny_rings();
        for (int c = 1; c <= 3; c++) begin
            write_capacity(c[CAPREG_W-1:0]);
            random_words(100, 50, 25, 24);
        end
    endtask

    // full depth ring, peeks up to the oldest entry
    task automatic test_full_depth();
        write_capacity(9'd256);
        sender_no_gaps    = 1'b1;
        receiver_no_stall = 1'b1;
        random_words(150, 70, 10, 20);
        sender_no_gaps    = 1'b0;
        receiver_no_stall = 1'b0;
        random_words(250, 60, 12, 27);
    endtask

    // out of range capacity values
    task automatic test_clamped_capacity();
        write_capacity(9'd0);
        random_words(100, 50, 25, 24);
        write_capacity(CAPREG_W'($urandom_range(257, 511)));
        random_words(100, 55, 15, 28);
    endtask

    // sender stops until every expected word has come back
    task automatic test_hold_until_drained();
        write_capacity(CAPREG_W'($urandom_range(2, 40)));
        for (int k = 0; k < 5; k++) begin
            random_words(30, 50, 20, 28);
            wait_for_results();
        end
    endtask

    // random capacities over the whole register range
    task automatic test_random_capacities();
        for (int k = 0; k < 8; k++) begin
            write_capacity(CAPREG_W'($urandom_range(0, 511)));
            random_words(35, 50, 20, 28);
        end
    endtask

    initial begin
        empty_ring_model(CAP_RESET[CAPREG_W-1:0]);
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_tiny_rings();
        test_full_depth();
        test_clamped_capacity();
        test_hold_until_drained();
        test_random_capacities();

        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("overwrite_ring_buffer_tb: done, clean");
        end else begin
            $display("overwrite_ring_buffer_tb: done, errors");
        end
        $finish;
    end

    // run limit
    initial begin
        #1000000;
        $display("overwrite_ring_buffer_tb: done, errors");
        $finish;
    end

endmodule

### files.f
design/orb_pkg.sv
design/orb_ram.sv
design/orb_ctrl.sv
design/overwrite_ring_buffer.sv
verif/overwrite_ring_buffer_tb.sv
